>>> rtl/rre_pkg.sv
// Package for the renewal Rt estimator: widths, status codes, config indexes,
// sequencer state, datapath control and status structs, and the tap weight lookup.
// Depends on nothing.
`default_nettype none
package rre_pkg;

  localparam int MAX_TAPS  = 16;
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int DAYS_W    = TAP_W + 1;
  localparam int CNT_W     = 20;
  localparam int WT_W      = 16;
  localparam int WPR       = 4;                    // weights packed per register
  localparam int NUM_WREGS = MAX_TAPS / WPR;
  localparam int CFG_W     = WT_W * WPR;
  localparam int CFG_IDX_W = 3;
  localparam int WSUM_W    = WT_W + TAP_W;
  localparam int ACC_W     = WT_W + CNT_W + TAP_W;
  localparam int PROD_W    = CNT_W + WSUM_W;
  localparam int RT_W      = 32;
  localparam int ST_W      = 2;
  localparam int NUM_W     = PROD_W + 16;
  localparam int QCNT_W    = $clog2(RT_W);

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = CFG_IDX_W'(NUM_WREGS);
  localparam int TAPCFG_W = DAYS_W;

  localparam logic [ST_W-1:0] ST_VALID = 2'd0;
  localparam logic [ST_W-1:0] ST_SAT   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDEF = 2'd2;

  typedef logic [WPR-1:0][WT_W-1:0] wreg_t;
  typedef wreg_t [NUM_WREGS-1:0]    wregs_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MAC   = 6'b000010,
    S_NUM   = 6'b000100,
    S_CHECK = 6'b001000,
    S_DIV   = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  typedef struct packed {
    logic clear;     // start of an item: zero the sums
    logic mac_en;    // history word and weight are present
    logic acc_en;    // product register holds a tap product
    logic num_en;    // form count * weight sum
    logic load_div;  // build numerator, load the divider
    logic div_step;  // one restoring division step
  } arith_ctl_t;

  typedef struct packed {
    logic            acc_zero;
    logic            num_zero;
    logic            ovf;
    logic [RT_W-1:0] quotient;
  } arith_sts_t;

  function automatic logic [WT_W-1:0] tap_weight(input wregs_t regs,
                                                 input logic [TAP_W-1:0] j);
    return regs[j[TAP_W-1:2]][j[1:0]];
  endfunction

endpackage
`default_nettype wire

>>> rtl/rre_in_if.sv
// Input channel of the Rt estimator: one daily count per request.
// Depends on rre_pkg.
`default_nettype none
interface rre_in_if;
  import rre_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] infection_count;
  logic             first_day;

  modport source (output valid, output infection_count, output first_day, input ready);
  modport sink   (input valid, input infection_count, input first_day, output ready);
endinterface
`default_nettype wire

>>> rtl/rre_out_if.sv
// Result channel of the Rt estimator: one Q16.16 estimate and status per request.
// Depends on rre_pkg.
`default_nettype none
interface rre_out_if;
  import rre_pkg::*;

  logic            valid;
  logic            ready;
  logic [RT_W-1:0] reproduction_number;
  logic [ST_W-1:0] status;

  modport source (output valid, output reproduction_number, output status, input ready);
  modport sink   (input valid, input reproduction_number, input status, output ready);
endinterface
`default_nettype wire

>>> rtl/rre_hist_ram.sv
// Ring of the last MAX_TAPS daily counts: one write port, one registered read port.
// Depends on rre_pkg.
`default_nettype none
module rre_hist_ram (
  input  wire                       clk,
  input  wire                       we,
  input  wire [rre_pkg::TAP_W-1:0]  waddr,
  input  wire [rre_pkg::CNT_W-1:0]  wdata,
  input  wire [rre_pkg::TAP_W-1:0]  raddr,
  output logic [rre_pkg::CNT_W-1:0] rdata
);
  import rre_pkg::*;

  logic [CNT_W-1:0] mem [MAX_TAPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> rtl/rre_arith.sv
// Shared arithmetic unit: one multiplier for tap products and the warm-up numerator,
// accumulators, and a restoring divider stepped one quotient bit per cycle. Uses rre_pkg.
`default_nettype none
module rre_arith (
  input  wire                        clk,
  input  rre_pkg::arith_ctl_t        ctl,
  input  wire [rre_pkg::CNT_W-1:0]   hist_word,
  input  wire [rre_pkg::WT_W-1:0]    weight,
  input  wire [rre_pkg::CNT_W-1:0]   count,
  input  wire                        warm,
  output rre_pkg::arith_sts_t        sts
);
  import rre_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic [WSUM_W-1:0] wsum_r;
  logic [ACC_W-1:0]  rem_r;
  logic [RT_W-1:0]   q_r;

  logic [CNT_W-1:0]  mul_a;
  logic [WSUM_W-1:0] mul_b;
  logic [NUM_W-1:0]  num;
  logic [ACC_W-1:0]  num_hi;
  logic [ACC_W:0]    trial;
  logic [ACC_W:0]    diff;
  logic              fits;

  always_comb begin
    mul_a  = ctl.num_en ? count  : hist_word;
    mul_b  = ctl.num_en ? wsum_r : WSUM_W'(weight);
    num    = warm ? {prod_r, 16'd0} : NUM_W'({count, 32'd0});
    num_hi = ACC_W'(num[NUM_W-1:RT_W]);
    trial  = {rem_r, q_r[RT_W-1]};
    diff   = trial - {1'b0, acc_r};
    fits   = trial >= {1'b0, acc_r};
  end

  always_ff @(posedge clk) begin
    if (ctl.mac_en || ctl.num_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (ctl.clear) begin
      acc_r  <= '0;
      wsum_r <= '0;
    end else begin
      if (ctl.acc_en) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
      if (ctl.mac_en) begin
        wsum_r <= wsum_r + WSUM_W'(weight);
      end
    end
    if (ctl.load_div) begin
      rem_r <= num_hi;
      q_r   <= num[RT_W-1:0];
    end else if (ctl.div_step) begin
      rem_r <= fits ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
      q_r   <= {q_r[RT_W-2:0], fits};
    end
  end

  assign sts.acc_zero = (acc_r == '0);
  assign sts.num_zero = (num == '0);
  assign sts.ovf      = (num_hi >= acc_r);
  assign sts.quotient = q_r;
endmodule
`default_nettype wire

>>> rtl/renewal_rt_estimator.sv
// Renewal-equation Rt estimator. A request runs the tap loop, forms the numerator, is
// classified, and goes through the divider unless the case is zero or saturated.
// One request at a time: the next is taken once the last result reaches the output register,
// paced by the one-product-per-cycle tap loop and the 32-step bit-serial divider.
// Synchronous active-low reset clears control, day counters and config (tap_count 1);
// the history ring is not cleared and needs no clearing pass.
`default_nettype none
module renewal_rt_estimator (
  input  wire                            clk,
  input  wire                            rst_n,
  rre_in_if.sink                         in_ch,
  rre_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire [rre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rre_pkg::CFG_W-1:0]       cfg_wdata
);
  import rre_pkg::*;

  // Configuration registers
  wregs_t              weights_r;
  logic [TAPCFG_W-1:0] tap_count_r;
  logic [DAYS_W-1:0]   taps;

  // Sequencer and series state
  state_t             state_r, state_nxt;
  logic [TAP_W-1:0]   wp_r;
  logic [TAP_W-1:0]   cur_wp_r;
  logic [DAYS_W-1:0]  days_r;
  logic [DAYS_W-1:0]  used_r;
  logic [DAYS_W-1:0]  j_r;
  logic               warm_r;
  logic [CNT_W-1:0]   count_r;
  logic               v1_r, v2_r;
  logic [WT_W-1:0]    w_s1_r;
  logic [QCNT_W-1:0]  qcnt_r;
  logic               use_q_r;
  logic [RT_W-1:0]    res_rt_r;
  logic [ST_W-1:0]    res_st_r;

  // Output register
  logic               out_valid_r;
  logic [RT_W-1:0]    out_rt_r;
  logic [ST_W-1:0]    out_st_r;

  logic               in_acc;
  logic               issue;
  logic               out_free;
  logic [TAP_W-1:0]   wp_eff;
  logic [DAYS_W-1:0]  days_new;
  logic [TAP_W-1:0]   raddr;
  logic [CNT_W-1:0]   hist_word;
  arith_ctl_t         ctl;
  arith_sts_t         sts;

  // Clamp the tap count: zero acts as one, anything above MAX_TAPS as MAX_TAPS.
  always_comb begin
    priority if (tap_count_r == '0) begin
      taps = DAYS_W'(1);
    end else if (tap_count_r > TAPCFG_W'(MAX_TAPS)) begin
      taps = DAYS_W'(MAX_TAPS);
    end else begin
      taps = tap_count_r;
    end
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // First day restarts the ring pointer and the day counter before today's count lands.
  assign wp_eff   = in_ch.first_day ? '0 : wp_r;
  assign days_new = in_ch.first_day ? DAYS_W'(1)
                  : (days_r == DAYS_W'(MAX_TAPS)) ? days_r : days_r + DAYS_W'(1);

  // Tap j reads the count from j days back, newest first.
  assign issue = (state_r == S_MAC) && (j_r < used_r);
  assign raddr = cur_wp_r - j_r[TAP_W-1:0];

  assign out_free = !out_valid_r || out_ch.ready;

  rre_hist_ram u_hist (
    .clk   (clk),
    .we    (in_acc),
    .waddr (wp_eff),
    .wdata (in_ch.infection_count),
    .raddr (raddr),
    .rdata (hist_word)
  );

  always_comb begin
    ctl          = '0;
    ctl.clear    = in_acc;
    ctl.mac_en   = v1_r;
    ctl.acc_en   = v2_r;
    ctl.num_en   = (state_r == S_NUM);
    ctl.load_div = (state_r == S_CHECK);
    ctl.div_step = (state_r == S_DIV);
  end

  rre_arith u_arith (
    .clk       (clk),
    .ctl       (ctl),
    .hist_word (hist_word),
    .weight    (w_s1_r),
    .count     (count_r),
    .warm      (warm_r),
    .sts       (sts)
  );

  // Sequencer: accumulate taps, form the numerator, classify, divide if needed, deliver.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MAC;
      S_MAC:   if (!issue && !v1_r && !v2_r) state_nxt = S_NUM;
      S_NUM:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = (sts.acc_zero || sts.ovf) ? S_FIN : S_DIV;
      S_DIV:   if (qcnt_r == QCNT_W'(RT_W - 1)) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      weights_r   <= '0;
      tap_count_r <= TAPCFG_W'(1);
      wp_r        <= '0;
      days_r      <= '0;
      j_r         <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      qcnt_r      <= '0;
      use_q_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Config writes; indexes past the list are dropped.
      if (cfg_we) begin
        if (cfg_index < CFG_TAP_COUNT) begin
          weights_r[cfg_index[1:0]] <= cfg_wdata;
        end else if (cfg_index == CFG_TAP_COUNT) begin
          tap_count_r <= cfg_wdata[TAPCFG_W-1:0];
        end
      end

      if (in_acc) begin
        wp_r   <= wp_eff + TAP_W'(1);
        days_r <= days_new;
        j_r    <= '0;
      end else if (issue) begin
        j_r <= j_r + DAYS_W'(1);
      end

      v1_r <= issue;
      v2_r <= v1_r;

      if (state_r == S_CHECK) begin
        qcnt_r  <= '0;
        use_q_r <= !(sts.acc_zero || sts.ovf);
      end else if (state_r == S_DIV) begin
        qcnt_r <= qcnt_r + QCNT_W'(1);
      end

      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_wp_r <= wp_eff;
      count_r  <= in_ch.infection_count;
      used_r   <= (days_new < taps) ? days_new : taps;
      warm_r   <= (days_new < taps);
    end
    if (issue) begin
      w_s1_r <= tap_weight(weights_r, j_r[TAP_W-1:0]);
    end
    if (state_r == S_CHECK) begin
      priority if (sts.acc_zero && sts.num_zero) begin
        res_rt_r <= '0;
        res_st_r <= ST_UNDEF;
      end else if (sts.acc_zero || sts.ovf) begin
        res_rt_r <= '1;
        res_st_r <= ST_SAT;
      end else begin
        res_rt_r <= '0;
        res_st_r <= ST_VALID;
      end
    end
    if (state_r == S_FIN && out_free) begin
      out_rt_r <= use_q_r ? sts.quotient : res_rt_r;
      out_st_r <= res_st_r;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.reproduction_number = out_rt_r;
  assign out_ch.status              = out_st_r;
endmodule
`default_nettype wire

>>> rtl/rre_checker.sv
// Port-level checks for the Rt estimator, bound to the top level.
// Depends on rre_pkg and renewal_rt_estimator.
`default_nettype none
module rre_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire [rre_pkg::RT_W-1:0]   out_rt,
  input wire [rre_pkg::ST_W-1:0]   out_st
);
  import rre_pkg::*;

  // A result waiting on the sink holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rt) && $stable(out_st))
    else $error("stalled result changed");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_st == ST_UNDEF |-> out_rt == '0)
    else $error("zero over zero with nonzero estimate");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_st == ST_SAT |-> out_rt == '1)
    else $error("saturated estimate not at maximum");

  a_st_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_st == ST_VALID || out_st == ST_SAT || out_st == ST_UNDEF)
    else $error("undefined status code");
endmodule

bind renewal_rt_estimator rre_checker u_rre_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_rt    (out_ch.reproduction_number),
  .out_st    (out_ch.status)
);
`default_nettype wire
